/* design/jcb_pkg.sv */
// Package for the JVM compare and branch unit: opcode codes and the
// input and result word structs. No dependencies.
package jcb_pkg;

    typedef enum logic [4:0] {
        OP_LCMP      = 5'd0,
        OP_FCMPL     = 5'd1,
        OP_FCMPG     = 5'd2,
        OP_DCMPL     = 5'd3,
        OP_DCMPG     = 5'd4,
        OP_IFEQ      = 5'd5,
        OP_IFNE      = 5'd6,
        OP_IFLT      = 5'd7,
        OP_IFGE      = 5'd8,
        OP_IFGT      = 5'd9,
        OP_IFLE      = 5'd10,
        OP_IF_ICMPEQ = 5'd11,
        OP_IF_ICMPNE = 5'd12,
        OP_IF_ICMPLT = 5'd13,
        OP_IF_ICMPGE = 5'd14,
        OP_IF_ICMPGT = 5'd15,
        OP_IF_ICMPLE = 5'd16,
        OP_IF_ACMPEQ = 5'd17,
        OP_IF_ACMPNE = 5'd18
    } op_t;

    localparam logic [15:0] PC_STEP_CMP = 16'd1;
    localparam logic [15:0] PC_STEP_BR  = 16'd3;

    typedef struct packed {
        logic [4:0]         op;
        logic signed [63:0] value_deep;
        logic signed [63:0] value_top;
        logic signed [15:0] branch_offset;
        logic [15:0]        pc_now;
    } in_word_t;

    typedef struct packed {
        logic signed [1:0] compare_value;
        logic              pushes_value;
        logic              branch_taken;
        logic [15:0]       pc_next;
    } out_word_t;

endpackage

/* design/jvm_compare_and_branch_unit.sv */
// Top level of the JVM compare and branch unit: input register, compare
// logic, result register. Depends on jcb_pkg.
//
// channel   direction  handshake           payload
// command   in         start / busy        in_word  (jcb_pkg::in_word_t)
// result    out        done (one cycle)    result   (jcb_pkg::out_word_t)
//
// Each word is captured in the input register, evaluated, and held in the
// result register for one cycle with done high. A new word is accepted
// every cycle; busy is always low. Reset clears only the valid flags.
// The receiver cannot stall, so no skid storage is needed.
module jvm_compare_and_branch_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  jcb_pkg::in_word_t  in_word,
    output logic               done,
    output jcb_pkg::out_word_t result
);

    jcb_pkg::in_word_t  in_reg;
    logic               in_vld_reg;
    jcb_pkg::out_word_t res_reg;
    jcb_pkg::out_word_t res_next;
    logic               res_vld_reg;

    assign busy   = 1'b0;
    assign done   = res_vld_reg;
    assign result = res_reg;

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= start;
            res_vld_reg <= in_vld_reg;
        end
    end

    // Payload registers: capture on accept, advance the result each cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_reg <= in_word;
        end
        res_reg <= res_next;
    end

    // Float ordering keys: sign-magnitude mapped to unsigned order
    function automatic logic signed [1:0] fp_cmp64(input logic [63:0] a,
                                                   input logic [63:0] b,
                                                   input logic nan_g);
        logic [63:0] ka;
        logic [63:0] kb;
        logic        nan;
        nan = ((a[62:52] == 11'h7FF) && (a[51:0] != '0)) ||
              ((b[62:52] == 11'h7FF) && (b[51:0] != '0));
        ka  = a[63] ? ~a : (a | {1'b1, 63'd0});
        kb  = b[63] ? ~b : (b | {1'b1, 63'd0});
        if (nan)
            fp_cmp64 = nan_g ? 2'sd1 : -2'sd1;
        else if ((a[62:0] == '0) && (b[62:0] == '0))
            fp_cmp64 = 2'sd0;
        else if (ka > kb)
            fp_cmp64 = 2'sd1;
        else if (ka == kb)
            fp_cmp64 = 2'sd0;
        else
            fp_cmp64 = -2'sd1;
    endfunction

    function automatic logic signed [1:0] fp_cmp32(input logic [31:0] a,
                                                   input logic [31:0] b,
                                                   input logic nan_g);
        logic [31:0] ka;
        logic [31:0] kb;
        logic        nan;
        nan = ((a[30:23] == 8'hFF) && (a[22:0] != '0)) ||
              ((b[30:23] == 8'hFF) && (b[22:0] != '0));
        ka  = a[31] ? ~a : (a | {1'b1, 31'd0});
        kb  = b[31] ? ~b : (b | {1'b1, 31'd0});
        if (nan)
            fp_cmp32 = nan_g ? 2'sd1 : -2'sd1;
        else if ((a[30:0] == '0) && (b[30:0] == '0))
            fp_cmp32 = 2'sd0;
        else if (ka > kb)
            fp_cmp32 = 2'sd1;
        else if (ka == kb)
            fp_cmp32 = 2'sd0;
        else
            fp_cmp32 = -2'sd1;
    endfunction

    logic signed [31:0] i_deep;
    logic signed [31:0] i_top;
    logic               z_eq, z_lt, p_eq, p_lt, r_eq;
    logic [15:0]        pc_taken;

    assign i_deep   = in_reg.value_deep[31:0];
    assign i_top    = in_reg.value_top[31:0];
    assign z_eq     = (i_top == 32'sd0);
    assign z_lt     = i_top[31];
    assign p_eq     = (i_deep == i_top);
    assign p_lt     = (i_deep < i_top);
    assign r_eq     = (in_reg.value_deep == in_reg.value_top);
    assign pc_taken = in_reg.pc_now + in_reg.branch_offset;

    // Decode and evaluate
    always_comb
    begin
        logic br;
        logic tk;
        br = 1'b1;
        tk = 1'b0;
        res_next.compare_value = 2'sd0;
        res_next.pushes_value  = 1'b0;
        case (in_reg.op)
            jcb_pkg::OP_LCMP:
            begin
                br = 1'b0;
                res_next.pushes_value  = 1'b1;
                res_next.compare_value =
                    (in_reg.value_deep > in_reg.value_top) ? 2'sd1 :
                    (r_eq ? 2'sd0 : -2'sd1);
            end
            jcb_pkg::OP_FCMPL, jcb_pkg::OP_FCMPG:
            begin
                br = 1'b0;
                res_next.pushes_value  = 1'b1;
                res_next.compare_value = fp_cmp32(in_reg.value_deep[31:0],
                    in_reg.value_top[31:0], in_reg.op == jcb_pkg::OP_FCMPG);
            end
            jcb_pkg::OP_DCMPL, jcb_pkg::OP_DCMPG:
            begin
                br = 1'b0;
                res_next.pushes_value  = 1'b1;
                res_next.compare_value = fp_cmp64(in_reg.value_deep,
                    in_reg.value_top, in_reg.op == jcb_pkg::OP_DCMPG);
            end
            jcb_pkg::OP_IFEQ:      tk = z_eq;
            jcb_pkg::OP_IFNE:      tk = !z_eq;
            jcb_pkg::OP_IFLT:      tk = z_lt;
            jcb_pkg::OP_IFGE:      tk = !z_lt;
            jcb_pkg::OP_IFGT:      tk = !z_lt && !z_eq;
            jcb_pkg::OP_IFLE:      tk = z_lt || z_eq;
            jcb_pkg::OP_IF_ICMPEQ: tk = p_eq;
            jcb_pkg::OP_IF_ICMPNE: tk = !p_eq;
            jcb_pkg::OP_IF_ICMPLT: tk = p_lt;
            jcb_pkg::OP_IF_ICMPGE: tk = !p_lt;
            jcb_pkg::OP_IF_ICMPGT: tk = !p_lt && !p_eq;
            jcb_pkg::OP_IF_ICMPLE: tk = p_lt || p_eq;
            jcb_pkg::OP_IF_ACMPEQ: tk = r_eq;
            jcb_pkg::OP_IF_ACMPNE: tk = !r_eq;
            default:               br = 1'b0;
        endcase
        res_next.branch_taken = tk;
        if (tk)
            res_next.pc_next = pc_taken;
        else if (br)
            res_next.pc_next = in_reg.pc_now + jcb_pkg::PC_STEP_BR;
        else
            res_next.pc_next = in_reg.pc_now + jcb_pkg::PC_STEP_CMP;
    end

    // A result follows every accepted word, through the input and result registers
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start) |=> done)
        else $error("result word missing after accept");

    // Compare words never report a taken branch
    a_push_no_branch: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.pushes_value |-> !result.branch_taken)
        else $error("compare word flagged as taken branch");

    // Branch words push nothing
    a_branch_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.pushes_value |-> result.compare_value == 2'sd0)
        else $error("nonzero compare value without push");

endmodule

/* tb/tb_jcb_checker.sv */
// Checker for the JVM compare and branch unit: watches accepted command words
// and result words, predicts each result and compares. Depends on jcb_pkg.
module tb_jcb_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  jcb_pkg::in_word_t  in_word,
    input  logic               done,
    input  jcb_pkg::out_word_t result,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    jcb_pkg::out_word_t expected_q[$];

    // Compare two IEEE values; is_dbl picks the width, nan_res the unordered answer.
    function automatic int fp_order(logic [63:0] a, logic [63:0] b, bit is_dbl,
                                    int nan_res);
        logic [63:0] sgn;
        logic [63:0] msk;
        logic [63:0] mant;
        logic [63:0] expm;
        logic [63:0] ka;
        logic [63:0] kb;
        sgn  = is_dbl ? 64'h8000_0000_0000_0000 : 64'h8000_0000;
        msk  = is_dbl ? '1 : 64'hFFFF_FFFF;
        mant = is_dbl ? 64'h000F_FFFF_FFFF_FFFF : 64'h007F_FFFF;
        expm = msk & ~sgn & ~mant;
        a = a & msk;
        b = b & msk;
        if (((a & expm) == expm && (a & mant) != 0) ||
            ((b & expm) == expm && (b & mant) != 0))
            return nan_res;
        if ((a & ~sgn) == 0 && (b & ~sgn) == 0)
            return 0;
        ka = (a & sgn) != 0 ? (~a & msk) : (a | sgn);
        kb = (b & sgn) != 0 ? (~b & msk) : (b | sgn);
        return (ka > kb) ? 1 : ((ka == kb) ? 0 : -1);
    endfunction

    function automatic int sorder(longint a, longint b);
        return (a > b) ? 1 : ((a == b) ? 0 : -1);
    endfunction

    function automatic bit cond_met(int code, int r);
        case (code)
            0: return r == 0;
            1: return r != 0;
            2: return r < 0;
            3: return r >= 0;
            4: return r > 0;
            default: return r <= 0;
        endcase
    endfunction

    function automatic jcb_pkg::out_word_t predict_branch(jcb_pkg::in_word_t w);
        jcb_pkg::out_word_t r;
        int cv;
        bit t;
        int x;
        int y;
        x = w.value_deep[31:0];
        y = w.value_top[31:0];
        r = '0;
        r.pc_next = w.pc_now + jcb_pkg::PC_STEP_CMP;
        cv = 0;
        t = 0;
        case (w.op)
            jcb_pkg::OP_LCMP:  cv = sorder(w.value_deep, w.value_top);
            jcb_pkg::OP_FCMPL: cv = fp_order(w.value_deep, w.value_top, 0, -1);
            jcb_pkg::OP_FCMPG: cv = fp_order(w.value_deep, w.value_top, 0, 1);
            jcb_pkg::OP_DCMPL: cv = fp_order(w.value_deep, w.value_top, 1, -1);
            jcb_pkg::OP_DCMPG: cv = fp_order(w.value_deep, w.value_top, 1, 1);
            jcb_pkg::OP_IF_ACMPEQ: t = w.value_deep == w.value_top;
            jcb_pkg::OP_IF_ACMPNE: t = w.value_deep != w.value_top;
            default:
            begin
                if (w.op >= jcb_pkg::OP_IFEQ && w.op <= jcb_pkg::OP_IFLE)
                    t = cond_met(w.op - jcb_pkg::OP_IFEQ, sorder(y, 0));
                else if (w.op >= jcb_pkg::OP_IF_ICMPEQ && w.op <= jcb_pkg::OP_IF_ICMPLE)
                    t = cond_met(w.op - jcb_pkg::OP_IF_ICMPEQ, sorder(x, y));
            end
        endcase
        if (w.op <= jcb_pkg::OP_DCMPG)
        begin
            r.compare_value = cv[1:0];
            r.pushes_value = 1'b1;
        end
        else if (w.op <= jcb_pkg::OP_IF_ACMPNE)
        begin
            r.branch_taken = t;
            r.pc_next = t ? w.pc_now + w.branch_offset
                          : w.pc_now + jcb_pkg::PC_STEP_BR;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        jcb_pkg::out_word_t exp_w;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // Retire the result first: a word accepted this edge cannot be done yet.
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result word %h", result);
                end
                else
                begin
                    exp_w = expected_q.pop_front();
                    if (result !== exp_w)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: cv %0d/%0d push %b/%b taken %b/%b pc %h/%h",
                                exp_w.compare_value, result.compare_value,
                                exp_w.pushes_value, result.pushes_value,
                                exp_w.branch_taken, result.branch_taken,
                                exp_w.pc_next, result.pc_next);
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(predict_branch(in_word));
            pending <= expected_q.size();
        end
    end
endmodule

/* tb/tb_top.sv */
// Testbench top for the JVM compare and branch unit: drives command words
// and gives the verdict. Depends on jcb_pkg, jvm_compare_and_branch_unit and tb_jcb_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    jcb_pkg::in_word_t  in_word;
    logic               done;
    jcb_pkg::out_word_t result;
    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    int                 idle_pct;

    jvm_compare_and_branch_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .in_word(in_word), .done(done), .result(result)
    );

    tb_jcb_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_word(in_word),
        .done(done), .result(result), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Watchdog: stops the run with a failure if it does not finish.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Pick an operand biased toward edge values and IEEE specials.
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0: v = 64'h7FF0_0000_0000_0000 | (v & 64'h8000_0000_0000_0001);  // double inf / NaN
            1: v = {v[63:32], 32'h7F80_0000 | (v[31:0] & 32'h8000_0001)};     // float inf / NaN
            2: v = v & 64'h8000_0000_8000_0000;                               // signed zeros
            3: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0, $urandom_range(0, 4) - 2};
            4: v = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            5: v = {v[63:32], $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
            default: ;
        endcase
        return v;
    endfunction

    // Send one word, holding start until it is accepted, with an optional idle gap.
    task automatic send_word(logic [4:0] op, logic [63:0] deep, logic [63:0] top,
                             logic [15:0] offs, logic [15:0] pc);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        in_word <= '{op: op, value_deep: deep, value_top: top, branch_offset: offs, pc_now: pc};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random(int count);
        logic [63:0] deep;
        for (int i = 0; i < count; i++)
        begin
            deep = pick_value();
            // Equal operands often, so eq branches and zero compares happen.
            send_word($urandom_range(0, 31) < 29
                          ? 5'($urandom_range(0, jcb_pkg::OP_IF_ACMPNE))
                          : 5'($urandom_range(19, 31)),
                      deep, $urandom_range(0, 3) == 0 ? deep : pick_value(),
                      16'($urandom), 16'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        in_word = '0;
        idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every opcode, NaN in both forms, signed zeros, wrap of pc.
        for (int o = 0; o <= jcb_pkg::OP_IF_ACMPNE; o++)
        begin
            send_word(5'(o), 64'h7FF8_0000_7FC0_0000, 64'h0, 16'h8000, 16'hFFFF);
        end
        send_word(jcb_pkg::OP_FCMPL, 64'h8000_0000, 64'h0, 16'h0, 16'h0);
        send_word(jcb_pkg::OP_DCMPG, 64'h8000_0000_0000_0000, 64'h0, 16'h7FFF, 16'hFFFF);
        send_word(jcb_pkg::OP_LCMP, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                  16'h0, 16'h0);
        send_word(jcb_pkg::OP_IF_ICMPGE, 64'h8000_0000, 64'h7FFF_FFFF, 16'hFFFD, 16'h0002);
        send_word(jcb_pkg::OP_IF_ICMPGE, 64'h1_0000_0005, 64'hFFFF_FFFF, 16'hFFFF, 16'h0001);
        send_word(5'd31, '1, '1, '1, 16'hFFFF);

        idle_pct = 8;
        send_random(480);
        idle_pct = 60;
        send_random(480);
        idle_pct = 0;
        send_random(480);
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
